/* rtl/core/mskd_pkg.sv */
package mskd_pkg;

   localparam int VALUE_W          = 16;
   localparam int OUT_W            = 23;
   localparam int CFG_W            = 5;
   localparam int DEF_MAX_LEN      = 128;
   localparam int DEF_MAX_SEGMENTS = 16;

   localparam logic [CFG_W-1:0] SEG_RESET = CFG_W'(1);

   typedef struct packed {
      logic load;
      logic grow;
      logic step_calc;
      logic fetch;
      logic report;
   } mskd_cmd_type;

   typedef struct packed {
      logic can_grow;
      logic at_end;
      logic last_item;
   } mskd_stat_type;

endpackage

/* rtl/core/mskd_ram.sv */
module mskd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/mskd_ctrl.sv */
module mskd_ctrl import mskd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          is_last,
   input  mskd_stat_type stat,
   output mskd_cmd_type  cmd,
   output logic          busy
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_READ   = 5'b00010,
      ST_CALC   = 5'b00100,
      ST_FETCH  = 5'b01000,
      ST_REPORT = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cmd.grow = stat.can_grow;
               if (stat.can_grow) begin
                  state_in = ST_READ;
               end else if (is_last) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.step_calc = 1'b1;
            if (!stat.at_end) begin
               state_in = ST_READ;
            end else if (stat.last_item) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_REPORT;
         end
         ST_REPORT: begin
            cmd.report = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* rtl/core/mskd_datapath.sv */
module mskd_datapath import mskd_pkg::*; #(
   parameter int MAX_LEN      = DEF_MAX_LEN,
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mskd_cmd_type               cmd,
   output mskd_stat_type              stat,
   input  logic signed [VALUE_W-1:0]  sample_value,
   input  logic                       is_last,
   input  logic                       cfg_we,
   input  logic [CFG_W-1:0]           cfg_data,
   output logic                       rsp_strobe,
   output logic signed [OUT_W-1:0]    rsp_best_sum,
   output logic                       rsp_feasible
);

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int DW    = VALUE_W + CNT_W + 2;
   localparam int DEPTH = MAX_SEGMENTS + 1;
   localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int JW    = $clog2(MAX_SEGMENTS + 2);
   localparam int WW    = JW > CFG_W ? JW : CFG_W;
   localparam int EW    = DW > OUT_W ? DW : OUT_W;

   localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
   localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

   logic [CNT_W-1:0]        count_ff;
   logic signed [DW-1:0]    prefix_ff;
   logic [JW-1:0]           j_ff;
   logic                    last_ff;
   logic signed [DW-1:0]    new_prev_ff;
   logic                    new_prev_ok_ff;
   logic [DEPTH-1:0]        prev_vld_ff;
   logic [DEPTH-1:0]        m_vld_ff;
   logic [CFG_W-1:0]        seg_ff;
   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_sum_ff;
   logic                    rsp_ok_ff;

   logic [AW-1:0]           prev_rd_addr;
   logic [AW-1:0]           jidx;
   logic [JW-1:0]           mi;
   logic [AW-1:0]           midx;
   logic [DW-1:0]           prev_rd;
   logic [DW-1:0]           m_rd;
   logic signed [DW-1:0]    p_val;
   logic                    p_ok;
   logic signed [DW-1:0]    m_val;
   logic                    m_ok;
   logic signed [DW-1:0]    cand;
   logic signed [DW-1:0]    new_val;
   logic                    new_ok;
   logic signed [DW-1:0]    upd;
   logic                    m_we;
   logic                    prev_we;
   logic [WW-1:0]           seg_w;
   logic [WW-1:0]           want_w;
   logic [AW-1:0]           want;
   logic                    want_ok;
   logic signed [EW-1:0]    best_ext;
   logic signed [EW-1:0]    best_sat;
   logic signed [DW-1:0]    sample_ext;

   assign stat.can_grow  = (count_ff < CNT_W'(MAX_LEN));
   assign stat.at_end    = (j_ff == JW'(MAX_SEGMENTS + 1));
   assign stat.last_item = last_ff;

   assign sample_ext = {{(DW - VALUE_W){sample_value[VALUE_W-1]}}, sample_value};

   assign seg_w  = WW'(seg_ff);
   assign want_w = (seg_w > WW'(MAX_SEGMENTS)) ? WW'(MAX_SEGMENTS) : seg_w;
   assign want   = want_w[AW-1:0];

   assign jidx = stat.at_end ? '0 : j_ff[AW-1:0];
   assign mi   = j_ff - JW'(1);
   assign midx = mi[AW-1:0];

   assign prev_rd_addr = cmd.fetch ? want : jidx;

   assign p_val = prev_rd;
   assign p_ok  = !stat.at_end && prev_vld_ff[jidx];
   assign m_val = m_vld_ff[midx] ? signed'(m_rd) : '0;
   assign m_ok  = m_vld_ff[midx] || (mi == '0);
   assign cand  = m_val + prefix_ff;

   always_comb begin
      if (m_ok && (!p_ok || cand > p_val)) begin
         new_val = cand;
         new_ok  = 1'b1;
      end else begin
         new_val = p_val;
         new_ok  = p_ok;
      end
   end

   assign upd     = new_prev_ff - prefix_ff;
   assign m_we    = cmd.step_calc && new_prev_ok_ff && (!m_ok || upd > m_val);
   assign prev_we = cmd.step_calc && !stat.at_end;

   assign want_ok  = (want == '0) || prev_vld_ff[want];
   assign best_ext = EW'(signed'(prev_rd));

   always_comb begin
      if (best_ext > SAT_HI) begin
         best_sat = SAT_HI;
      end else if (best_ext < SAT_LO) begin
         best_sat = SAT_LO;
      end else begin
         best_sat = best_ext;
      end
   end

   mskd_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (jidx),
      .wr_data (new_val),
      .rd_addr (prev_rd_addr),
      .rd_data (prev_rd)
   );

   mskd_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_gain_ram (
      .clock   (clock),
      .wr_en   (m_we),
      .wr_addr (midx),
      .wr_data (upd),
      .rd_addr (midx),
      .rd_data (m_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         prefix_ff    <= '0;
         prev_vld_ff  <= '0;
         m_vld_ff     <= '0;
         seg_ff       <= SEG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (cfg_we) begin
            seg_ff <= cfg_data;
         end
         if (cmd.load) begin
            last_ff <= is_last;
            if (cmd.grow) begin
               prefix_ff      <= prefix_ff + sample_ext;
               count_ff       <= count_ff + CNT_W'(1);
               j_ff           <= JW'(1);
               new_prev_ff    <= '0;
               new_prev_ok_ff <= 1'b1;
            end
         end
         if (cmd.step_calc) begin
            if (prev_we) begin
               prev_vld_ff[jidx] <= new_ok;
            end
            if (m_we) begin
               m_vld_ff[midx] <= 1'b1;
            end
            new_prev_ff    <= new_val;
            new_prev_ok_ff <= new_ok;
            j_ff           <= j_ff + JW'(1);
         end
         if (cmd.report) begin
            rsp_valid_ff <= 1'b1;
            rsp_ok_ff    <= want_ok;
            rsp_sum_ff   <= (want != '0 && want_ok) ? best_sat[OUT_W-1:0] : '0;
            count_ff     <= '0;
            prefix_ff    <= '0;
            prev_vld_ff  <= '0;
            m_vld_ff     <= '0;
         end
      end
   end

   assign rsp_strobe   = rsp_valid_ff;
   assign rsp_best_sum = rsp_sum_ff;
   assign rsp_feasible = rsp_ok_ff;

endmodule

/* rtl/core/max_sum_k_disjoint_segments.sv */
// Each accepted beat runs a read and an update state per segment count, 1 to
// MAX_SEGMENTS+1; beats past MAX_LEN samples are accepted without an update pass.
// A req_is_last beat then passes FETCH and REPORT; rsp_strobe pulses for one cycle.
// One beat in flight at a time; for a last beat busy is high until its result is out.
// Synchronous active-high reset clears the sequence and sets segment_count to 1.
// The receiver cannot stall: a result is presented for exactly one cycle.
module max_sum_k_disjoint_segments import mskd_pkg::*; #(
   parameter int MAX_LEN      = DEF_MAX_LEN,
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [VALUE_W-1:0] req_sample_value,
   input  logic                      req_is_last,
   output logic                      rsp_strobe,
   output logic signed [OUT_W-1:0]   rsp_best_sum,
   output logic                      rsp_feasible,
   input  logic                      csr_write_enable,
   input  logic [CFG_W-1:0]          csr_write_data
);

   mskd_cmd_type  cmd;
   mskd_stat_type stat;

   mskd_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .is_last (req_is_last),
      .stat    (stat),
      .cmd     (cmd),
      .busy    (busy)
   );

   mskd_datapath #(
      .MAX_LEN      (MAX_LEN),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .sample_value (req_sample_value),
      .is_last      (req_is_last),
      .cfg_we       (csr_write_enable),
      .cfg_data     (csr_write_data),
      .rsp_strobe   (rsp_strobe),
      .rsp_best_sum (rsp_best_sum),
      .rsp_feasible (rsp_feasible)
   );

endmodule
